// File: rtl/etb_pkg.sv
// Shared types and constants for the event timer bank.
package etb_pkg;

    localparam int TimersDefault = 16;
    localparam int ReqW          = 3;
    localparam int WordW         = 32;
    localparam int ActiveW       = 16;

    typedef enum logic [ReqW-1:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_SET   = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    // One timer slot as held in the slot memory.
    typedef struct packed {
        logic [WordW-1:0] events;
        logic [WordW-1:0] reload;
        logic [WordW-1:0] count;
    } t_slot_rec;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a request transfer happens this cycle
        logic rd_en;    // read one slot record for the tick walk
        logic ld_out;   // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy; // result register holds a result that is not taken this cycle
    } t_dp_stat;

endpackage

// File: rtl/event_timer_bank_top.sv
// Top level of the event timer bank: stream ports, controller and datapath.
//
// Requests arrive on the slave stream (i_s_*). The request kind travels in
// tuser: tick, start timer, stop timer, set events or clear events. The mask,
// interval and repeat mode travel in tdata. Every request produces exactly one
// result transfer on the master stream (o_m_*) carrying the pending event
// word, the enable bits of slots 0 to 15 and the events fired by a tick.
// A tick walks all TIMERS slots one per cycle through a single shared
// decrementer fed from the slot memory, whose read port is pipelined
// ahead of the update. A drain state then finishes the last slot and a
// done state loads the result register; the block takes the next request
// after that load. Any other request goes straight to the done state and
// frees the input once its result is loaded. The slot walk sets the tick
// latency, plus the drain state and the done state that loads the result.
// One request is in work at a time. A finished result sits in an output
// register, so the next request is accepted while the receiver stalls;
// that request then waits to deliver until the register is taken.
// The synchronous active-low reset disables every slot, clears the pending
// word and empties the output register. The slot memory needs no clearing.
module event_timer_bank_top #(
    parameter int TIMERS = etb_pkg::TimersDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // event_mask[31:0], interval[63:32], repeat_mode[64], zero fill
    input  logic [2:0]  i_s_tuser,  // req_type[2:0]
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata   // pending_events[31:0], active_timers[47:32], fired_events[79:48]
);

    localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    etb_pkg::t_dp_cmd             cmd;
    etb_pkg::t_dp_stat            stat;
    logic [SW-1:0]                rd_addr;
    logic [etb_pkg::WordW-1:0]    pending_events;
    logic [etb_pkg::ActiveW-1:0]  active_timers;
    logic [etb_pkg::WordW-1:0]    fired_events;

    etb_ctrl #(
        .TIMERS (TIMERS),
        .SW     (SW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_req_type (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    etb_datapath #(
        .TIMERS (TIMERS),
        .SW     (SW)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .i_req_type       (i_s_tuser),
        .i_event_mask     (i_s_tdata[31:0]),
        .i_interval       (i_s_tdata[63:32]),
        .i_repeat_mode    (i_s_tdata[64]),
        .i_m_tready       (i_m_tready),
        .o_stat           (stat),
        .o_out_valid      (o_m_tvalid),
        .o_pending_events (pending_events),
        .o_active_timers  (active_timers),
        .o_fired_events   (fired_events)
    );

    assign o_m_tdata = {fired_events, active_timers, pending_events};

endmodule

// File: rtl/etb_ctrl.sv
// Controller state machine: accepts requests and sequences the tick walk.
module etb_ctrl #(
    parameter int TIMERS = etb_pkg::TimersDefault,
    parameter int SW     = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic [etb_pkg::ReqW-1:0] i_req_type,
    input  etb_pkg::t_dp_stat        i_stat,
    output logic                     o_s_tready,
    output etb_pkg::t_dp_cmd         o_cmd,
    output logic [SW-1:0]            o_rd_addr
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TICK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic        accept;
    logic        last_slot;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign last_slot  = (r_idx == SW'(TIMERS - 1));
    assign o_rd_addr  = r_idx;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd.accept = accept;
        o_cmd.rd_en  = 1'b0;
        o_cmd.ld_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (i_req_type == etb_pkg::REQ_TICK) begin
                        n_state = ST_TICK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_TICK: begin
                o_cmd.rd_en = 1'b1;
                if (last_slot) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// File: rtl/etb_datapath.sv
// Datapath: slot memory, enable and repeat bits, pending word, decrementer and result register.
module etb_datapath #(
    parameter int TIMERS = etb_pkg::TimersDefault,
    parameter int SW     = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  etb_pkg::t_dp_cmd            i_cmd,
    input  logic [SW-1:0]               i_rd_addr,
    input  logic [etb_pkg::ReqW-1:0]    i_req_type,
    input  logic [etb_pkg::WordW-1:0]   i_event_mask,
    input  logic [etb_pkg::WordW-1:0]   i_interval,
    input  logic                        i_repeat_mode,
    input  logic                        i_m_tready,
    output etb_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    output logic [etb_pkg::WordW-1:0]   o_pending_events,
    output logic [etb_pkg::ActiveW-1:0] o_active_timers,
    output logic [etb_pkg::WordW-1:0]   o_fired_events
);

    // Count, reload and mask of each slot. Only used while the slot is enabled,
    // and every enable is preceded by a full write, so no reset is needed.
    etb_pkg::t_slot_rec mem [TIMERS];

    logic [TIMERS-1:0]          r_enable, n_enable;
    logic [TIMERS-1:0]          r_repeat, n_repeat;
    logic [etb_pkg::WordW-1:0]  r_pending, n_pending;
    logic [etb_pkg::WordW-1:0]  r_fired, n_fired;
    etb_pkg::t_slot_rec         r_rd_data;
    logic                       r_proc_v;
    logic [SW-1:0]              r_pidx;

    logic                       wr_en;
    logic [SW-1:0]              wr_addr;
    etb_pkg::t_slot_rec         wr_data;

    logic                       found;
    logic [SW-1:0]              pick;
    logic [etb_pkg::ActiveW-1:0] active;

    logic                       r_out_valid;
    logic [etb_pkg::WordW-1:0]  r_out_pending;
    logic [etb_pkg::ActiveW-1:0] r_out_active;
    logic [etb_pkg::WordW-1:0]  r_out_fired;

    // Lowest set bit of the mask among the slot positions.
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (i_event_mask[i]) begin
                found = 1'b1;
                pick  = SW'(i);
            end
        end
    end

    for (genvar gi = 0; gi < etb_pkg::ActiveW; gi++) begin : g_active
        if (gi < TIMERS) begin : g_slot
            assign active[gi] = r_enable[gi];
        end else begin : g_none
            assign active[gi] = 1'b0;
        end
    end

    always_comb begin
        n_enable  = r_enable;
        n_repeat  = r_repeat;
        n_pending = r_pending;
        n_fired   = r_fired;
        wr_en     = 1'b0;
        wr_addr   = r_pidx;
        wr_data   = r_rd_data;

        if (i_cmd.accept) begin
            n_fired = '0;
            case (i_req_type)
                etb_pkg::REQ_START: begin
                    if (found && !r_enable[pick]) begin
                        wr_en          = 1'b1;
                        wr_addr        = pick;
                        wr_data.events = i_event_mask;
                        wr_data.reload = i_interval;
                        wr_data.count  = i_interval;
                        n_repeat[pick] = i_repeat_mode;
                        n_enable[pick] = 1'b1;
                    end
                end
                etb_pkg::REQ_STOP: begin
                    if (found && r_enable[pick]) begin
                        n_repeat[pick] = 1'b0;
                        n_enable[pick] = 1'b0;
                    end
                end
                etb_pkg::REQ_SET: begin
                    n_pending = r_pending | i_event_mask;
                end
                etb_pkg::REQ_CLEAR: begin
                    n_pending = r_pending & ~i_event_mask;
                end
                default: begin
                end
            endcase
        end

        // One slot of the tick walk, in the cycle after its record was read.
        if (r_proc_v && r_enable[r_pidx]) begin
            wr_en = 1'b1;
            if (r_rd_data.count != '0) begin
                wr_data.count = r_rd_data.count - 1'b1;
            end else begin
                n_pending = n_pending | r_rd_data.events;
                n_fired   = n_fired | r_rd_data.events;
                if (r_repeat[r_pidx]) begin
                    wr_data.count = r_rd_data.reload;
                end else begin
                    n_enable[r_pidx] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
        r_pidx <= i_rd_addr;
        if (i_cmd.ld_out) begin
            r_out_pending <= r_pending;
            r_out_active  <= active;
            r_out_fired   <= r_fired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= '0;
            r_repeat    <= '0;
            r_pending   <= '0;
            r_fired     <= '0;
            r_proc_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_enable  <= n_enable;
            r_repeat  <= n_repeat;
            r_pending <= n_pending;
            r_fired   <= n_fired;
            r_proc_v  <= i_cmd.rd_en;
            if (i_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy  = r_out_valid && !i_m_tready;
    assign o_out_valid      = r_out_valid;
    assign o_pending_events = r_out_pending;
    assign o_active_timers  = r_out_active;
    assign o_fired_events   = r_out_fired;

endmodule

// File: tb/sv/tb_event_timer_bank_top.sv
// Self-checking testbench for the event timer bank: stimulus, bank predictor and result checks.
module tb_event_timer_bank_top;

    localparam int Timers      = etb_pkg::TimersDefault;
    localparam int CycleLimit  = 500000;   // far above the slowest legal run
    localparam int HoldCycles  = 80;       // length of a long output stall
    localparam int DrainCycles = Timers + 8;
    localparam int RandomItems = 700;

    // Request codes that the block must treat as no-ops.
    localparam logic [2:0] ReqUnknownLo = 3'd5;
    localparam logic [2:0] ReqUnknownHi = 3'd7;

    // One result word as the block reports it.
    typedef struct {
        logic [31:0] pending;
        logic [15:0] active;
        logic [31:0] fired;
    } t_bank_status;

    // Tracks the timer bank state and holds the status words still owed by the block.
    class timer_bank_scoreboard;
        bit          slot_on       [Timers];
        bit          slot_periodic [Timers];
        bit [31:0]   slot_left     [Timers];
        bit [31:0]   slot_period   [Timers];
        bit [31:0]   slot_mask     [Timers];
        bit [31:0]   pending_word;
        t_bank_status status_due [$];
        int mismatches;
        int unexpected;
        int results_seen;
        int ticks;
        int firing_ticks;
        int starts_loaded;
        int stops_done;
        int no_slot_requests;

        function int first_slot(logic [31:0] mask);
            for (int i = 0; i < Timers && i < 32; i++) begin
                if (mask[i]) return i;
            end
            return -1;
        endfunction

        function logic [31:0] run_tick();
            logic [31:0] fired;
            fired = '0;
            for (int i = 0; i < Timers; i++) begin
                if (slot_on[i]) begin
                    if (slot_left[i] != 0) begin
                        slot_left[i] = slot_left[i] - 1;
                    end else begin
                        pending_word |= slot_mask[i];
                        fired        |= slot_mask[i];
                        if (slot_periodic[i]) slot_left[i] = slot_period[i];
                        else slot_on[i] = 1'b0;
                    end
                end
            end
            return fired;
        endfunction

        // Apply one accepted request to the bank and queue the status it must produce.
        function void note_request(logic [2:0] req, logic [31:0] mask, logic [31:0] ivl,
                                   logic rep);
            t_bank_status st;
            int slot;
            st.fired = '0;
            slot = first_slot(mask);
            case (req)
                etb_pkg::REQ_TICK: begin
                    st.fired = run_tick();
                    ticks++;
                    if (st.fired != 0) firing_ticks++;
                end
                etb_pkg::REQ_START: begin
                    if (slot < 0) begin
                        no_slot_requests++;
                    end else if (!slot_on[slot]) begin
                        slot_mask[slot]     = mask;
                        slot_left[slot]     = ivl;
                        slot_period[slot]   = ivl;
                        slot_periodic[slot] = rep;
                        slot_on[slot]       = 1'b1;
                        starts_loaded++;
                    end
                end
                etb_pkg::REQ_STOP: begin
                    if (slot < 0) begin
                        no_slot_requests++;
                    end else if (slot_on[slot]) begin
                        slot_mask[slot]     = '0;
                        slot_left[slot]     = '0;
                        slot_period[slot]   = '0;
                        slot_periodic[slot] = 1'b0;
                        slot_on[slot]       = 1'b0;
                        stops_done++;
                    end
                end
                etb_pkg::REQ_SET:   pending_word |= mask;
                etb_pkg::REQ_CLEAR: pending_word &= ~mask;
                default: ;
            endcase
            st.pending = pending_word;
            st.active  = '0;
            for (int i = 0; i < Timers && i < 16; i++) st.active[i] = slot_on[i];
            status_due.push_back(st);
        endfunction

        // Compare one result transfer with the oldest status still owed.
        function void check_result(logic [79:0] data);
            t_bank_status want;
            logic [31:0] got_pending;
            logic [15:0] got_active;
            logic [31:0] got_fired;
            got_pending = data[31:0];
            got_active  = data[47:32];
            got_fired   = data[79:48];
            results_seen++;
            if (status_due.size() == 0) begin
                unexpected++;
                $display("ERROR: result with nothing outstanding: pending=%h active=%h fired=%h",
                         got_pending, got_active, got_fired);
                return;
            end
            want = status_due.pop_front();
            if (got_pending !== want.pending || got_active !== want.active ||
                got_fired !== want.fired) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d: pending %h/%h active %h/%h fired %h/%h",
                              " (expected/actual)"}, results_seen,
                             want.pending, got_pending, want.active, got_active,
                             want.fired, got_fired);
            end
        endfunction

        function int waiting();
            return status_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;   // event_mask[31:0], interval[63:32], repeat_mode[64], zero fill
    logic [2:0]  i_s_tuser;   // req_type[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;   // pending_events[31:0], active_timers[47:32], fired_events[79:48]

    timer_bank_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    int holds_done    = 0;
    int cycle_count   = 0;

    event_timer_bank_top #(.TIMERS(Timers)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.waiting());
            $display("tb_event_timer_bank_top NOT OK");
            $finish;
        end
    end

    // Result side. The ready line changes on the falling edge. A hold request from the
    // stimulus keeps it low for a long stretch so that the block backs up into its input.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                holds_done++;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every result transfer is checked at the rising edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // Offer one request, with random idle cycles first, and hand it to the scoreboard
    // once the transfer has happened. Valid stays high between back-to-back requests.
    task automatic send_request(input logic [2:0] req, input logic [31:0] mask,
                                input logic [31:0] ivl, input logic rep);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, rep, ivl, mask};
        i_s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(req, mask, ivl, rep);
    endtask

    // One random request. Most starts and stops carry a well-formed slot mask and short
    // intervals so that timers actually fire; the rest is noise.
    task automatic send_random_request();
        int          pick;
        int          slot;
        logic [2:0]  req;
        logic [31:0] mask;
        logic [31:0] ivl;
        logic        rep;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, Timers - 1);
        mask = ($urandom() << slot) | (32'd1 << slot);
        ivl  = $urandom();
        rep  = 1'($urandom_range(0, 1));
        if (pick < 45) begin
            req = etb_pkg::REQ_TICK;
        end else if (pick < 65) begin
            req = etb_pkg::REQ_START;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: ivl = $urandom_range(0, 6);
                7, 8:                ivl = $urandom_range(0, 40);
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0) mask = $urandom();
        end else if (pick < 76) begin
            req = etb_pkg::REQ_STOP;
            if ($urandom_range(0, 9) == 0) mask = $urandom();
        end else if (pick < 84) begin
            req  = etb_pkg::REQ_SET;
            mask = $urandom();
        end else if (pick < 93) begin
            req  = etb_pkg::REQ_CLEAR;
            mask = $urandom();
        end else if (pick < 97) begin
            // Mask bits only above the slot range: start and stop must ignore it.
            req  = $urandom_range(0, 1) ? etb_pkg::REQ_START : etb_pkg::REQ_STOP;
            mask = $urandom() & ~((32'd1 << Timers) - 1);
        end else begin
            req  = 3'($urandom_range(ReqUnknownLo, ReqUnknownHi));
            mask = $urandom();
        end
        send_request(req, mask, ivl, rep);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: firing, reload, busy and idle slots, masks without a slot bit,
        // the widest interval, full-word set and clear, and the unused request codes.
        send_request(etb_pkg::REQ_TICK,  32'h0000_0000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_START, 32'h0000_0001, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_TICK,  32'h0000_0000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_START, 32'hFFFF_8000, 32'd1,         1'b1);
        send_request(etb_pkg::REQ_START, 32'h0000_8000, 32'd5,         1'b0);
        repeat (4) send_request(etb_pkg::REQ_TICK, 32'h0000_0000, 32'd0, 1'b0);
        send_request(etb_pkg::REQ_STOP,  32'h0000_8000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_STOP,  32'h0000_8000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_START, 32'h0001_0000, 32'd3,         1'b1);
        send_request(etb_pkg::REQ_STOP,  32'hFFFF_0000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(etb_pkg::REQ_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(etb_pkg::REQ_SET,   32'hFFFF_FFFF, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_CLEAR, 32'h0000_FFFF, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_START, 32'h0000_0000, 32'd2,         1'b1);
        send_request(ReqUnknownLo, 32'hA5A5_A5A5, 32'd7,               1'b1);
        send_request(ReqUnknownHi, 32'hFFFF_FFFF, 32'd0,               1'b0);
        send_request(etb_pkg::REQ_START, 32'h0000_0008, 32'd0,         1'b1);
        send_request(etb_pkg::REQ_TICK,  32'h0000_0000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_TICK,  32'h0000_0000, 32'd0,         1'b0);
        send_request(etb_pkg::REQ_STOP,  32'h0000_0001, 32'd0,         1'b0);

        // Random part in three phases: slow receiver, slow sender, then full speed.
        // A long output stall is forced in the second and third phases.
        send_idle_pct = 19;
        recv_idle_pct = 84;
        repeat (RandomItems / 3) send_random_request();

        send_idle_pct = 84;
        recv_idle_pct = 19;
        for (int n = 0; n < RandomItems / 3; n++) begin
            if (n == RandomItems / 6) hold_req = 1'b1;
            send_random_request();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (RandomItems - 2 * (RandomItems / 3)) send_random_request();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (sb.waiting() != 0)
            $display("ERROR: %0d results never arrived", sb.waiting());
        $display("Covered %0d results: %0d ticks (%0d firing), %0d timers loaded, %0d stopped.",
                 sb.results_seen, sb.ticks, sb.firing_ticks, sb.starts_loaded, sb.stops_done);
        $display("Also %0d start/stop requests without a slot bit and %0d long output stalls.",
                 sb.no_slot_requests, holds_done);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.waiting() == 0) begin
            $display("tb_event_timer_bank_top OK");
        end else begin
            $display("%0d mismatched and %0d unexpected results", sb.mismatches, sb.unexpected);
            $display("tb_event_timer_bank_top NOT OK");
        end
        $finish;
    end

endmodule
